// ===== rtl/rihs_pkg.sv =====
// Shared constants, types and the arctangent table of the RGB to IHS converter.
package rihs_pkg;

  localparam int PIX_W        = 8;
  localparam int OUT_W        = 16;
  localparam int CORDIC_STEPS = 30;
  localparam int ANG_W        = 32;
  localparam int CW           = 43;
  localparam int DEN_W        = 11;

  localparam logic [30:0]      SQRT3_Q30 = 31'h6ED9_EBA1;
  localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;

  typedef logic [OUT_W-1:0] result_t;

  // Arctangent of 2^-idx in units of 2^32 per full turn.
  function automatic logic [ANG_W-1:0] atan_turn(input logic [4:0] idx);
    logic [ANG_W-1:0] a;
    case (idx)
      5'd0:  a = 32'h2000_0000;
      5'd1:  a = 32'h12E4_051D;
      5'd2:  a = 32'h09FB_385B;
      5'd3:  a = 32'h0511_11D4;
      5'd4:  a = 32'h028B_0D43;
      5'd5:  a = 32'h0145_D7E1;
      5'd6:  a = 32'h00A2_F61E;
      5'd7:  a = 32'h0051_7C55;
      5'd8:  a = 32'h0028_BE53;
      5'd9:  a = 32'h0014_5F2E;
      5'd10: a = 32'h000A_2F98;
      5'd11: a = 32'h0005_17CC;
      5'd12: a = 32'h0002_8BE6;
      5'd13: a = 32'h0001_45F3;
      5'd14: a = 32'h0000_A2F9;
      5'd15: a = 32'h0000_517C;
      5'd16: a = 32'h0000_28BE;
      5'd17: a = 32'h0000_145F;
      5'd18: a = 32'h0000_0A2F;
      5'd19: a = 32'h0000_0517;
      5'd20: a = 32'h0000_028B;
      5'd21: a = 32'h0000_0145;
      5'd22: a = 32'h0000_00A2;
      5'd23: a = 32'h0000_0051;
      5'd24: a = 32'h0000_0028;
      5'd25: a = 32'h0000_0014;
      5'd26: a = 32'h0000_000A;
      5'd27: a = 32'h0000_0005;
      5'd28: a = 32'h0000_0002;
      5'd29: a = 32'h0000_0001;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/rihs_cordic_hue.sv =====
// Pipelined CORDIC vectoring unit that turns the hue vector into a scaled hue angle.
module rihs_cordic_hue #(
  parameter int FRAC_BITS = 8,
  parameter int PAD       = 0
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [rihs_pkg::CW-1:0] x_in,
  input  logic signed [rihs_pkg::CW-1:0] y_in,
  output rihs_pkg::result_t             hue
);
  import rihs_pkg::*;

  localparam int FULL_W = PIX_W + FRAC_BITS;
  localparam int PROD_W = ANG_W + FULL_W;
  localparam logic [FULL_W-1:0] FULL = {8'd255, {FRAC_BITS{1'b0}}};

  logic signed [CW-1:0]    x_r  [0:CORDIC_STEPS];
  logic signed [CW-1:0]    y_r  [0:CORDIC_STEPS];
  logic        [ANG_W-1:0] z_r  [0:CORDIC_STEPS];
  logic                    yz_r [0:CORDIC_STEPS];
  logic                    xn_r [0:CORDIC_STEPS];

  logic [ANG_W-1:0]  z_fin;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_rnd;
  logic [FULL_W-1:0] hue_raw;
  logic [OUT_W-1:0]  hue_nxt;
  logic [OUT_W-1:0]  hue_fin_r;

  // A vector in the left half-plane is turned by half a turn first.
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]  <= x_in[CW-1] ? -x_in : x_in;
      y_r[0]  <= x_in[CW-1] ? -y_in : y_in;
      z_r[0]  <= x_in[CW-1] ? HALF_TURN : '0;
      yz_r[0] <= (y_in == '0);
      xn_r[0] <= x_in[CW-1];
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_r[i][CW-1] && (y_r[i] != '0)) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_turn(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_turn(5'(i));
        end
        yz_r[i+1] <= yz_r[i];
        xn_r[i+1] <= xn_r[i];
      end
    end
  end

  // With no vertical component the angle is either zero or half a turn.
  assign z_fin = yz_r[CORDIC_STEPS] ? (xn_r[CORDIC_STEPS] ? HALF_TURN : '0)
                                    : z_r[CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(z_fin) * PROD_W'(FULL);
    end
  end

  assign prod_rnd = prod_r + (PROD_W'(1) << (ANG_W - 1));
  assign hue_raw  = prod_rnd[PROD_W-1:ANG_W];

  always_comb begin
    if (hue_raw >= FULL) begin
      hue_nxt = '0;
    end else if (32'(hue_raw) > 32'h0000_FFFF) begin
      hue_nxt = '1;
    end else begin
      hue_nxt = OUT_W'(hue_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue_fin_r <= hue_nxt;
    end
  end

  if (PAD == 0) begin : g_nopad
    assign hue = hue_fin_r;
  end else begin : g_pad
    logic [OUT_W-1:0] pad_r [0:PAD-1];
    always_ff @(posedge clk) begin
      if (en) begin
        pad_r[0] <= hue_fin_r;
        for (int k = 1; k < PAD; k++) begin
          pad_r[k] <= pad_r[k-1];
        end
      end
    end
    assign hue = pad_r[PAD-1];
  end

endmodule

// ===== rtl/rihs_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a saturated 16-bit result.
module rihs_divider #(
  parameter int N   = 27,
  parameter int PAD = 0
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [N-1:0]                    num,
  input  logic [rihs_pkg::DEN_W-1:0]      den,
  output rihs_pkg::result_t               q
);
  import rihs_pkg::*;

  logic [N-1:0]     nq_r  [0:N];
  logic [DEN_W-1:0] d_r   [0:N];
  logic [DEN_W-1:0] rem_r [0:N];
  logic [OUT_W-1:0] q_fin_r;

  always_ff @(posedge clk) begin
    if (en) begin
      nq_r[0]  <= num;
      d_r[0]   <= den;
      rem_r[0] <= '0;
    end
  end

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  for (genvar i = 0; i < N; i++) begin : g_row
    logic [DEN_W:0] sh;
    logic           ge;
    logic [DEN_W:0] diff;
    assign sh   = {rem_r[i], nq_r[i][N-1]};
    assign ge   = (sh >= {1'b0, d_r[i]});
    assign diff = sh - {1'b0, d_r[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
        nq_r[i+1]  <= {nq_r[i][N-2:0], ge};
        d_r[i+1]   <= d_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_fin_r <= (|nq_r[N][N-1:OUT_W]) ? '1 : nq_r[N][OUT_W-1:0];
    end
  end

  if (PAD == 0) begin : g_nopad
    assign q = q_fin_r;
  end else begin : g_pad
    logic [OUT_W-1:0] pad_r [0:PAD-1];
    always_ff @(posedge clk) begin
      if (en) begin
        pad_r[0] <= q_fin_r;
        for (int k = 1; k < PAD; k++) begin
          pad_r[k] <= pad_r[k-1];
        end
      end
    end
    assign q = pad_r[PAD-1];
  end

endmodule

// ===== rtl/rgb_to_ihs_pixel_converter.sv =====
// RGB to intensity, hue and saturation converter, top level.
//
// The input channel takes one 8-bit RGB pixel per request (in_red, in_green,
// in_blue); the output channel gives intensity, hue and saturation in unsigned
// fixed point with FRAC_BITS fraction bits. A request is taken at a clock edge
// where valid is high and stall is low, on either channel.
// Throughput is one pixel per cycle while out_stall stays low. The hue goes
// through the 30-step CORDIC pipeline and the saturation through the
// one-bit-per-stage divider; the shallower of the two is padded to match the
// deeper. The intensity is found in two stages and delayed to match.
// The whole pipeline moves as one: while a result waits with out_stall high,
// every stage holds and in_stall is raised, so nothing is lost or repeated.
// Empty stages travel as bubbles with their valid bit low.
// Synchronous reset clears all valid bits; data registers are not reset.
module rgb_to_ihs_pixel_converter #(
  parameter int FRAC_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rihs_pkg::PIX_W-1:0]      in_red,
  input  logic [rihs_pkg::PIX_W-1:0]      in_green,
  input  logic [rihs_pkg::PIX_W-1:0]      in_blue,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rihs_pkg::result_t               out_intensity,
  output rihs_pkg::result_t               out_hue,
  output rihs_pkg::result_t               out_saturation
);
  import rihs_pkg::*;

  localparam int N     = FRAC_BITS + 19;
  localparam int LAT_C = CORDIC_STEPS + 3;
  localparam int LAT_D = N + 2;
  localparam int LAT   = (LAT_C > LAT_D) ? LAT_C : LAT_D;
  localparam int PAD_C = LAT - LAT_C;
  localparam int PAD_D = LAT - LAT_D;
  localparam int PAD_I = LAT - 2;
  localparam int IW    = PIX_W + FRAC_BITS + 1;
  localparam int C1    = ((1 << FRAC_BITS) + 1) / 3;
  localparam int C2    = ((2 << FRAC_BITS) + 1) / 3;
  localparam logic [31:0] FULL32 = 32'(255) << FRAC_BITS;
  localparam logic [15:0] CAP    = (FULL32 > 32'h0000_FFFF) ? 16'hFFFF : FULL32[15:0];

  logic             en;
  logic [LAT:0]     v_r;
  logic [PIX_W-1:0] r_r, g_r, b_r;

  logic [9:0]             sum;
  logic [7:0]             mn;
  logic [9:0]             diff;
  logic [17:0]            num255;
  logic signed [10:0]     x_d;
  logic signed [8:0]      y_d;
  logic signed [40:0]     y_prod;
  logic signed [CW-1:0]   x_c, y_c;
  logic [N-1:0]           sat_num;
  logic [DEN_W-1:0]       sat_den;

  logic [19:0]            q3_prod;
  logic [PIX_W-1:0]       q3;
  logic [1:0]             r3;
  logic [PIX_W-1:0]       int_q_r;
  logic [1:0]             int_rem_r;
  logic [IW-1:0]          int_raw;
  logic [OUT_W-1:0]       int_nxt;
  logic [OUT_W-1:0]       int_fin_r;
  logic [OUT_W-1:0]       int_dly_r [0:PAD_I-1];

  assign in_stall  = out_valid && out_stall;
  assign en        = !in_stall;
  assign out_valid = v_r[LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r <= in_red;
      g_r <= in_green;
      b_r <= in_blue;
    end
  end

  always_comb begin
    mn = (r_r < g_r) ? r_r : g_r;
    if (b_r < mn) begin
      mn = b_r;
    end
  end

  assign sum    = 10'(r_r) + 10'(g_r) + 10'(b_r);
  assign diff   = sum - 10'(3 * mn);
  assign num255 = 18'(diff) * 18'd255;
  assign x_d    = $signed({2'b00, r_r, 1'b0}) - $signed({3'b000, g_r})
                  - $signed({3'b000, b_r});
  assign y_d    = $signed({1'b0, g_r}) - $signed({1'b0, b_r});
  assign y_prod = 41'(y_d) * 41'($signed({1'b0, SQRT3_Q30}));
  assign x_c    = {{(CW-41){x_d[10]}}, x_d, 30'b0};
  assign y_c    = CW'(y_prod);

  // Rounded mean floor((sum * 2^FRAC_BITS + 1) / 3): the sum is split into
  // quotient and remainder by three, and the remainder adds a fixed fraction.
  assign q3_prod = 20'(sum) * 20'd683;
  assign q3      = q3_prod[18:11];
  assign r3      = 2'(sum - 10'(3 * q3));

  always_comb begin
    case (int_rem_r)
      2'd1:    int_raw = (IW'(int_q_r) << FRAC_BITS) + IW'(C1);
      2'd2:    int_raw = (IW'(int_q_r) << FRAC_BITS) + IW'(C2);
      default: int_raw = IW'(int_q_r) << FRAC_BITS;
    endcase
    int_nxt = (32'(int_raw) > 32'h0000_FFFF) ? '1 : OUT_W'(int_raw);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      int_q_r      <= q3;
      int_rem_r    <= r3;
      int_fin_r    <= int_nxt;
      int_dly_r[0] <= int_fin_r;
      for (int k = 1; k < PAD_I; k++) begin
        int_dly_r[k] <= int_dly_r[k-1];
      end
    end
  end

  assign out_intensity = int_dly_r[PAD_I-1];

  // A black pixel divides zero by one, which gives zero saturation.
  assign sat_num = (N'(num255) << (FRAC_BITS + 1)) + N'(sum);
  assign sat_den = (sum == '0) ? DEN_W'(1) : DEN_W'({sum, 1'b0});

  rihs_cordic_hue #(.FRAC_BITS(FRAC_BITS), .PAD(PAD_C)) u_hue (
    .clk  (clk),
    .en   (en),
    .x_in (x_c),
    .y_in (y_c),
    .hue  (out_hue)
  );

  rihs_divider #(.N(N), .PAD(PAD_D)) u_sat (
    .clk (clk),
    .en  (en),
    .num (sat_num),
    .den (sat_den),
    .q   (out_saturation)
  );

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hue)
      && $stable(out_intensity) && $stable(out_saturation))
    else $error("stalled result changed");

  a_sat_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_saturation <= CAP)
    else $error("saturation above full scale");

  a_int_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_intensity <= CAP)
    else $error("intensity above full scale");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the RGB to IHS pixel converter.
`timescale 1ns / 100ps

module testbench;
  import rihs_pkg::*;

  localparam int FRAC_BITS    = 8;
  localparam int NUM_RANDOM   = 1500;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    result_t intensity;
    result_t hue;
    result_t saturation;
  } ihs_t;

  typedef struct {
    pixel_t pix;
    logic   known;
    ihs_t   res;
  } stim_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [PIX_W-1:0] in_red;
  logic [PIX_W-1:0] in_green;
  logic [PIX_W-1:0] in_blue;
  logic             out_valid;
  logic             out_stall;
  result_t          out_intensity;
  result_t          out_hue;
  result_t          out_saturation;

  ihs_t        pending_ihs[$];
  stim_row_t   directed_rows[$];
  int unsigned error_count;
  int unsigned pixels_sent;
  int unsigned results_seen;
  int unsigned idle_cycles;

  rgb_to_ihs_pixel_converter #(.FRAC_BITS(FRAC_BITS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_intensity(out_intensity), .out_hue(out_hue),
    .out_saturation(out_saturation)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint floor_shr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic logic [ANG_W-1:0] cordic_angle(input longint x0, input longint y0);
    longint           x;
    longint           y;
    longint           dx;
    longint           dy;
    logic [ANG_W-1:0] z;
    x = x0;
    y = y0;
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + atan_turn(i[4:0]);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - atan_turn(i[4:0]);
      end
    end
    return z;
  endfunction

  function automatic result_t clip16(input longint unsigned v);
    return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic ihs_t convert_pixel(input pixel_t p);
    longint           r;
    longint           g;
    longint           b;
    longint           mn;
    longint unsigned  sum;
    longint unsigned  full;
    longint unsigned  num;
    longint unsigned  hue;
    logic [ANG_W-1:0] z;
    ihs_t             o;
    r = longint'(p.red);
    g = longint'(p.green);
    b = longint'(p.blue);
    sum = r + g + b;
    full = 64'd255 << FRAC_BITS;
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    o.intensity = clip16(((sum << FRAC_BITS) * 2 + 3) / 6);
    if (sum == 0) begin
      o.saturation = '0;
    end else begin
      num = (64'd255 * (sum - 3 * mn)) << FRAC_BITS;
      o.saturation = clip16((2 * num + sum) / (2 * sum));
    end
    if (g == b) begin
      z = ((2 * r - g - b) < 0) ? HALF_TURN : '0;
    end else begin
      z = cordic_angle((2 * r - g - b) * (64'sd1 <<< 30), (g - b) * longint'(SQRT3_Q30));
    end
    hue = ((longint'(z) * full) + (64'd1 << 31)) >> 32;
    if (hue >= full) hue = 0;
    o.hue = clip16(hue);
    return o;
  endfunction

  task automatic report_mismatch(input string what, input result_t got, input result_t want);
    $display("MISMATCH %s: got %h, expected %h", what, got, want);
    error_count++;
  endtask

  task automatic add_row(input pixel_t p, input logic known, input ihs_t r);
    stim_row_t row;
    row.pix = p;
    row.known = known;
    row.res = r;
    directed_rows = {directed_rows, row};
  endtask

  task automatic send_pixel(input pixel_t p, input ihs_t want);
    in_valid <= 1'b1;
    in_red   <= p.red;
    in_green <= p.green;
    in_blue  <= p.blue;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_ihs = {pending_ihs, want};
    pixels_sent++;
  endtask

  // Bursts of back-to-back requests separated by random gaps.
  task automatic send_with_gaps(input pixel_t p, input ihs_t want, inout int burst_left);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    send_pixel(p, want);
    burst_left--;
  endtask

  // The receiver switches between stall-free stretches and random stalling.
  initial begin
    int mode;
    int left;
    out_stall = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(5, 60);
      end
      left--;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    ihs_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_ihs.size() == 0) begin
        report_mismatch("result with nothing outstanding, intensity", out_intensity, '0);
      end else begin
        want = pending_ihs.pop_front();
        if (out_intensity !== want.intensity)
          report_mismatch("intensity", out_intensity, want.intensity);
        if (out_hue !== want.hue) report_mismatch("hue", out_hue, want.hue);
        if (out_saturation !== want.saturation)
          report_mismatch("saturation", out_saturation, want.saturation);
      end
    end
  end

  // Watchdog on cycles with no request accepted on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout waiting for a request to be accepted");
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    pixel_t p;
    ihs_t   want;
    int     burst_left;
    int     kind;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_red = '0;
    in_green = '0;
    in_blue = '0;
    error_count = 0;
    pixels_sent = 0;
    results_seen = 0;
    idle_cycles = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Black: everything zero. White: full intensity, grey so no hue or saturation.
    add_row('{8'd0, 8'd0, 8'd0}, 1'b1, '{16'h0000, 16'h0000, 16'h0000});
    add_row('{8'd255, 8'd255, 8'd255}, 1'b1, '{16'hFF00, 16'h0000, 16'h0000});
    add_row('{8'd128, 8'd128, 8'd128}, 1'b1, '{16'h8000, 16'h0000, 16'h0000});
    // Pure red: hue zero, full saturation.
    add_row('{8'd255, 8'd0, 8'd0}, 1'b1, '{16'h5500, 16'h0000, 16'hFF00});
    add_row('{8'd0, 8'd255, 8'd0}, 1'b0, '0);
    add_row('{8'd0, 8'd0, 8'd255}, 1'b0, '0);
    // Blue equal to green, below red and above red.
    add_row('{8'd200, 8'd10, 8'd10}, 1'b0, '0);
    add_row('{8'd10, 8'd200, 8'd200}, 1'b0, '0);
    add_row('{8'd0, 8'd255, 8'd255}, 1'b0, '0);
    add_row('{8'd255, 8'd255, 8'd0}, 1'b0, '0);
    add_row('{8'd255, 8'd0, 8'd255}, 1'b0, '0);
    // Blue just above green, near the full turn.
    add_row('{8'd255, 8'd0, 8'd1}, 1'b0, '0);
    add_row('{8'd255, 8'd254, 8'd255}, 1'b0, '0);
    add_row('{8'd1, 8'd0, 8'd0}, 1'b0, '0);
    add_row('{8'd0, 8'd0, 8'd1}, 1'b0, '0);
    add_row('{8'd170, 8'd85, 8'd170}, 1'b0, '0);
    add_row('{8'd127, 8'd128, 8'd129}, 1'b0, '0);

    burst_left = 0;
    foreach (directed_rows[i]) begin
      want = directed_rows[i].known ? directed_rows[i].res : convert_pixel(directed_rows[i].pix);
      send_with_gaps(directed_rows[i].pix, want, burst_left);
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      kind = $urandom_range(0, 9);
      p.red   = 8'($urandom_range(0, 255));
      p.green = 8'($urandom_range(0, 255));
      p.blue  = 8'($urandom_range(0, 255));
      // Mix in greys, equal green and blue, near-equal pairs, and full red.
      if (kind == 0) begin
        p.green = p.red;
        p.blue = p.red;
      end else if (kind == 1) begin
        p.blue = p.green;
      end else if (kind == 2) begin
        p.blue = 8'(p.green + $urandom_range(0, 1));
      end else if (kind == 3) begin
        p.red = 8'd255;
      end
      send_with_gaps(p, convert_pixel(p), burst_left);
    end
    in_valid <= 1'b0;

    while (pending_ihs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d pixels (directed extremes, greys, equal green and blue, random)",
             pixels_sent);
    $display("Checked %0d results under random sender gaps and receiver stalls",
             results_seen);
    if (error_count == 0 && pending_ihs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
